// ===== design/som_pkg.sv =====
// Shared constants, types and the exponential factor table for the map training block.
`default_nettype none

package som_pkg;

  localparam int GRID_COLS_DEF = 8;
  localparam int GRID_ROWS_DEF = 8;
  localparam int VEC_LEN_DEF   = 4;

  localparam int W_W     = 24;   // weight, unsigned Q16.8
  localparam int FEAT_W  = 16;
  localparam int FEAT_N  = 4;    // feature fields on the input
  localparam int SEL_W   = 6;
  localparam int WIN_W   = 6;
  localparam int STEP_W  = 16;
  localparam int RATE_W  = 16;

  localparam int S_TDATA_W  = 72;
  localparam int M_TDATA_W  = 120;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam int ED_NUM_W = 62;  // widest dividend: d2 << 31
  localparam int ED_DEN_W = 41;  // widest divisor: squared radius in Q.16
  localparam int ED_Q_W   = 21;  // quotient bits that reach the exponential
  localparam int EXP_W    = 33;  // Q0.32 with room for 1.0
  localparam int D2_W     = 31;
  localparam int DXY_W    = 15;

  localparam logic [1:0] MODE_TRAIN    = 2'd0;
  localparam logic [1:0] MODE_CLASSIFY = 2'd1;
  localparam logic [1:0] MODE_WRITE    = 2'd2;
  localparam logic [1:0] MODE_READ     = 2'd3;

  localparam logic [CFG_ADDR_W-1:0] REG_INITIAL_RATE    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ITERATION_LIMIT = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_START_RADIUS    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_RADIUS_DECAY    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_CELL_W          = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_CELL_H          = 3'd5;

  typedef enum logic [1:0] {ED_IDLE, ED_DIV, ED_EXP} ed_state_t;

  typedef enum logic [4:0] {
    S_IDLE, S_SCAN, S_DRAIN, S_WS_GO, S_WS_WAIT, S_WS_MUL, S_D2A, S_D2B, S_CHK,
    S_INFL, S_F24, S_MAG, S_SHIFT, S_RATE_GO, S_RATE_WAIT, S_RATE_MUL, S_ACCESS, S_DONE
  } ctl_state_t;

  typedef struct packed {
    logic                start;
    logic [ED_NUM_W-1:0] num;
    logic [ED_DEN_W-1:0] den;
  } ed_req_t;

  // exp(-2^(k-16)) in Q0.32
  function automatic logic [31:0] exp_factor(input logic [4:0] k);
    logic [31:0] f;
    case (k)
      5'd0:  f = 32'd4294901760;
      5'd1:  f = 32'd4294836226;
      5'd2:  f = 32'd4294705160;
      5'd3:  f = 32'd4294443040;
      5'd4:  f = 32'd4293918848;
      5'd5:  f = 32'd4292870656;
      5'd6:  f = 32'd4290775039;
      5'd7:  f = 32'd4286586875;
      5'd8:  f = 32'd4278222805;
      5'd9:  f = 32'd4261543595;
      5'd10: f = 32'd4228380000;
      5'd11: f = 32'd4162825044;
      5'd12: f = 32'd4034748382;
      5'd13: f = 32'd3790295335;
      5'd14: f = 32'd3344923893;
      5'd15: f = 32'd2605029347;
      5'd16: f = 32'd1580030169;
      5'd17: f = 32'd581260615;
      5'd18: f = 32'd78665070;
      5'd19: f = 32'd1440801;
      5'd20: f = 32'd483;
      default: f = 32'd0;
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

// ===== design/som_train_step.sv =====
// Top level: node chain, winner search pipeline, neighbourhood update sequencer.
// Node weights sit in a ring of cells that rotates one node per shift; node 0 at the head.
// Train: the divide and exponential unit (21 + 21 steps) runs once for the radius,
//   once per node inside the radius and once for the new rate.
// One item at a time; a finished result waits in the output register while the next is taken.
// Reset (sync, active high): registers to defaults, step 0, rate = initial; weights undefined.
`default_nettype none

module som_train_step import som_pkg::*; #(
  parameter int GRID_COLS = GRID_COLS_DEF,
  parameter int GRID_ROWS = GRID_ROWS_DEF,
  parameter int VEC_LEN   = VEC_LEN_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,   // node_sel, feature_0, feature_1, feature_2, feature_3
  input  logic [1:0]            s_tuser,   // mode
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,   // winner, weight_0..3, steps_done
  output logic                  m_tuser,   // limit_hit
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int NODES  = GRID_COLS * GRID_ROWS;
  localparam int IDX_W  = NODES > 1 ? $clog2(NODES) : 1;
  localparam int COL_W  = GRID_COLS > 1 ? $clog2(GRID_COLS) : 1;
  localparam int ROW_W  = GRID_ROWS > 1 ? $clog2(GRID_ROWS) : 1;
  localparam int CMP_W  = IDX_W > SEL_W ? IDX_W : SEL_W;
  localparam int DIST_W = 2 * W_W + $clog2(VEC_LEN + 1);

  typedef logic [VEC_LEN-1:0][W_W-1:0] vec_t;

  ctl_state_t state, state_next;

  // configuration and training state
  logic [15:0] initial_rate, iteration_limit, radius_decay;
  logic [11:0] start_radius;
  logic [9:0]  cell_w, cell_h;
  logic [STEP_W-1:0] step_count;
  logic [RATE_W-1:0] current_rate;

  // item
  logic [1:0]                   mode;
  logic [SEL_W-1:0]             sel;
  logic [FEAT_N-1:0][FEAT_W-1:0] feat;
  vec_t                         vin;

  // ring
  vec_t             cell_q [NODES];
  vec_t             head, tail, new_w, wr_vec;
  logic             shift;
  logic [IDX_W-1:0] idx;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic             last_node;
  logic             hit;

  // winner search
  logic                          s1_valid, s2_valid;
  logic [IDX_W-1:0]              s1_idx, s2_idx, best_idx;
  logic [COL_W-1:0]              s1_col, s2_col, best_col;
  logic [ROW_W-1:0]              s1_row, s2_row, best_row;
  vec_t                          s1_ad;
  logic [VEC_LEN-1:0][2*W_W-1:0] s2_sq;
  logic [DIST_W-1:0]             sum_sq, best_d;

  // neighbourhood update
  logic [23:0]          sr2;
  logic [ED_DEN_W-1:0]  ws16;
  logic [DXY_W-1:0]     wx, wy, nx, ny, dx, dy, dx_c, dy_c;
  logic [D2_W-1:0]      d2, d2_c;
  logic                 in_nb, upd;
  logic [24:0]          f24;
  logic [48:0]          f24_prod;
  vec_t                 ad, mag, mag_c;
  logic [VEC_LEN-1:0]   dir;
  logic [56:0]          ws_prod;
  logic [47:0]          rate_prod;

  ed_req_t          ed_req;
  logic             ed_done;
  logic [EXP_W-1:0] ed_res;

  // result
  logic [WIN_W-1:0]              res_winner;
  logic [FEAT_N-1:0][W_W-1:0]    res_w, rd_w;
  logic                          res_limit;

  logic accept, limit_now;

  assign accept    = s_tvalid && s_tready;
  assign s_tready  = state == S_IDLE;
  assign cfg_ready = 1'b1;
  assign limit_now = step_count >= iteration_limit;

  for (genvar k = 0; k < VEC_LEN; k++) begin : g_vin
    if (k < FEAT_N) begin : g_f
      assign vin[k]    = {feat[k], {(W_W - FEAT_W){1'b0}}};
      assign wr_vec[k] = vin[k];
    end else begin : g_z
      assign vin[k]    = '0;
      assign wr_vec[k] = head[k];
    end
  end

  for (genvar k = 0; k < FEAT_N; k++) begin : g_rd
    if (k < VEC_LEN) begin : g_w
      assign rd_w[k] = head[k];
    end else begin : g_z
      assign rd_w[k] = '0;
    end
  end

  // ---------------- node ring ----------------
  assign head = cell_q[0];
  assign shift = state == S_SCAN || state == S_SHIFT || state == S_ACCESS;
  assign last_node = idx == IDX_W'(NODES - 1);
  assign hit = CMP_W'(idx) == CMP_W'(sel);

  for (genvar i = 0; i < NODES; i++) begin : g_cell
    vec_t din;
    if (i == NODES - 1) begin : g_tail
      assign din = tail;
    end else begin : g_mid
      assign din = cell_q[i+1];
    end
    som_cell #(.VEC_LEN(VEC_LEN)) u_cell (
      .clk  (clk),
      .shift(shift),
      .din  (din),
      .dout (cell_q[i])
    );
  end

  always_comb begin
    tail = head;
    if (state == S_SHIFT && upd) begin
      tail = new_w;
    end
    if (state == S_ACCESS && mode == MODE_WRITE && hit) begin
      tail = wr_vec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      col <= '0;
      row <= '0;
    end else if (shift) begin
      if (last_node) begin
        idx <= '0;
        col <= '0;
        row <= '0;
      end else begin
        idx <= idx + 1'b1;
        if (row == ROW_W'(GRID_ROWS - 1)) begin
          row <= '0;
          col <= col + 1'b1;
        end else begin
          row <= row + 1'b1;
        end
      end
    end
  end

  // ---------------- winner search ----------------
  always_comb begin
    sum_sq = '0;
    for (int k = 0; k < VEC_LEN; k++) begin
      sum_sq = sum_sq + DIST_W'(s2_sq[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= state == S_SCAN;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx <= idx;
    s1_col <= col;
    s1_row <= row;
    for (int k = 0; k < VEC_LEN; k++) begin
      s1_ad[k] <= vin[k] > head[k] ? vin[k] - head[k] : head[k] - vin[k];
      s2_sq[k] <= (2*W_W)'(s1_ad[k]) * (2*W_W)'(s1_ad[k]);
    end
    s2_idx <= s1_idx;
    s2_col <= s1_col;
    s2_row <= s1_row;
    // first smallest wins: strict compare
    if (s2_valid && (s2_idx == '0 || sum_sq < best_d)) begin
      best_d   <= sum_sq;
      best_idx <= s2_idx;
      best_col <= s2_col;
      best_row <= s2_row;
    end
  end

  // ---------------- divide / exponential unit ----------------
  always_comb begin
    ed_req.start = state == S_WS_GO || state == S_RATE_GO || (state == S_CHK && in_nb);
    case (state)
      S_WS_GO: begin
        ed_req.num = ED_NUM_W'({step_count, 17'h0});
        ed_req.den = ED_DEN_W'(radius_decay == 16'd0 ? 16'd1 : radius_decay);
      end
      S_RATE_GO: begin
        ed_req.num = ED_NUM_W'({17'(step_count) + 17'd1, 16'h0});
        ed_req.den = ED_DEN_W'(iteration_limit);
      end
      default: begin
        ed_req.num = {d2, 31'h0};
        ed_req.den = ws16;
      end
    endcase
  end

  som_expdiv u_expdiv (
    .clk (clk),
    .rst (rst),
    .req (ed_req),
    .done(ed_done),
    .res (ed_res)
  );

  // ---------------- neighbourhood arithmetic ----------------
  assign nx    = DXY_W'(col) * DXY_W'(cell_w);
  assign ny    = DXY_W'(row) * DXY_W'(cell_h);
  assign dx_c  = nx > wx ? nx - wx : wx - nx;
  assign dy_c  = ny > wy ? ny - wy : wy - ny;
  assign d2_c  = D2_W'(dx) * D2_W'(dx) + D2_W'(dy) * D2_W'(dy);
  assign in_nb = {d2, 16'h0} < 47'(ws16);

  assign ws_prod   = 57'(sr2) * 57'(ed_res);
  assign f24_prod  = 49'(current_rate) * 49'(ed_res) + 49'(24'h800000);
  assign rate_prod = 48'(initial_rate) * 48'(ed_res) + 48'(32'h80000000);

  always_comb begin
    for (int k = 0; k < VEC_LEN; k++) begin
      mag_c[k] = W_W'((49'(ad[k]) * 49'(f24) + 49'(24'h800000)) >> 24);
      new_w[k] = dir[k] ? head[k] + mag[k] : head[k] - mag[k];
    end
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (s_tuser)
            MODE_TRAIN:    state_next = limit_now ? S_DONE : S_SCAN;
            MODE_CLASSIFY: state_next = S_SCAN;
            default:       state_next = S_ACCESS;
          endcase
        end
      end
      S_SCAN:      if (last_node) state_next = S_DRAIN;
      S_DRAIN: begin
        if (!s1_valid && !s2_valid) begin
          state_next = mode == MODE_TRAIN ? S_WS_GO : S_DONE;
        end
      end
      S_WS_GO:     state_next = S_WS_WAIT;
      S_WS_WAIT:   if (ed_done) state_next = S_WS_MUL;
      S_WS_MUL:    state_next = S_D2A;
      S_D2A:       state_next = S_D2B;
      S_D2B:       state_next = S_CHK;
      S_CHK:       state_next = in_nb ? S_INFL : S_SHIFT;
      S_INFL:      if (ed_done) state_next = S_F24;
      S_F24:       state_next = S_MAG;
      S_MAG:       state_next = S_SHIFT;
      S_SHIFT:     state_next = last_node ? S_RATE_GO : S_D2A;
      S_RATE_GO:   state_next = S_RATE_WAIT;
      S_RATE_WAIT: if (ed_done) state_next = S_RATE_MUL;
      S_RATE_MUL:  state_next = S_DONE;
      S_ACCESS:    if (last_node) state_next = S_DONE;
      S_DONE:      if (!m_tvalid || m_tready) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          mode <= s_tuser;
          sel  <= s_tdata[SEL_W-1:0];
          for (int k = 0; k < FEAT_N; k++) begin
            feat[k] <= s_tdata[SEL_W + FEAT_W*k +: FEAT_W];
          end
          res_winner <= '0;
          res_w      <= '0;
          res_limit  <= s_tuser == MODE_TRAIN && limit_now;
        end
      end
      S_DRAIN:  res_winner <= WIN_W'(best_idx);
      S_WS_GO:  sr2 <= 24'(start_radius) * 24'(start_radius);
      S_WS_MUL: begin
        ws16 <= ws_prod[56:16];
        wx   <= DXY_W'(best_col) * DXY_W'(cell_w);
        wy   <= DXY_W'(best_row) * DXY_W'(cell_h);
      end
      S_D2A: begin
        dx <= dx_c;
        dy <= dy_c;
      end
      S_D2B:    d2 <= d2_c;
      S_CHK:    upd <= in_nb;
      S_F24: begin
        f24 <= f24_prod[48:24];
        for (int k = 0; k < VEC_LEN; k++) begin
          dir[k] <= vin[k] > head[k];
          ad[k]  <= vin[k] > head[k] ? vin[k] - head[k] : head[k] - vin[k];
        end
      end
      S_MAG:    mag <= mag_c;
      S_ACCESS: begin
        if (mode == MODE_READ && hit) begin
          res_w <= rd_w;
        end
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= {2'b00, step_count, res_w, res_winner};
          m_tuser <= res_limit;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_DONE && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // registers, step count and rate
  always_ff @(posedge clk) begin
    if (rst) begin
      initial_rate    <= 16'd6554;
      iteration_limit <= 16'd1000;
      start_radius    <= 12'd256;
      radius_decay    <= 16'd180;
      cell_w          <= 10'd64;
      cell_h          <= 10'd64;
      step_count      <= '0;
      current_rate    <= 16'd6554;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          REG_INITIAL_RATE: begin
            initial_rate <= cfg_data;
            if (step_count == '0) begin
              current_rate <= cfg_data;
            end
          end
          REG_ITERATION_LIMIT: iteration_limit <= cfg_data;
          REG_START_RADIUS:    start_radius    <= cfg_data[11:0];
          REG_RADIUS_DECAY:    radius_decay    <= cfg_data;
          REG_CELL_W:          cell_w          <= cfg_data[9:0];
          REG_CELL_H:          cell_h          <= cfg_data[9:0];
          default: ;
        endcase
      end
      if (state == S_RATE_MUL) begin
        current_rate <= rate_prod[47:32];
        step_count   <= step_count + 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_ring_aligned: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (idx == '0))
    else $error("node ring not aligned to node 0 when idle");

  a_ed_done_wait: assert property (@(posedge clk) disable iff (rst)
    ed_done |-> (state == S_WS_WAIT || state == S_INFL || state == S_RATE_WAIT))
    else $error("exp unit finished while sequencer not waiting");

  a_step_adv: assert property (@(posedge clk) disable iff (rst)
    (state == S_RATE_MUL) |=> (step_count == $past(step_count) + 16'd1))
    else $error("step count did not advance by one");

  a_limit_win: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[WIN_W-1:0] == '0))
    else $error("ignored train item reports a winner");
`endif

endmodule

`default_nettype wire

// ===== design/som_cell.sv =====
// One map node: its weight vector, passed to the neighbouring node on each shift.
`default_nettype none

module som_cell import som_pkg::*; #(
  parameter int VEC_LEN = VEC_LEN_DEF
) (
  input  logic                          clk,
  input  logic                          shift,
  input  logic [VEC_LEN-1:0][W_W-1:0]   din,
  output logic [VEC_LEN-1:0][W_W-1:0]   dout
);

  logic [VEC_LEN-1:0][W_W-1:0] w;

  always_ff @(posedge clk) begin
    if (shift) begin
      w <= din;
    end
  end

  assign dout = w;

endmodule

`default_nettype wire

// ===== design/som_expdiv.sv =====
// Shared unit: restoring divide, then exp(-q) one factor per cycle.
`default_nettype none

module som_expdiv import som_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  ed_req_t          req,
  output logic             done,
  output logic [EXP_W-1:0] res
);

  ed_state_t state, state_next;

  logic [ED_NUM_W-1:0] rem;
  logic [ED_NUM_W-2:0] dsh;
  logic [ED_Q_W-1:0]   q;
  logic [4:0]          cnt;
  logic [EXP_W-1:0]    r;
  logic                sat;
  logic                ge;
  logic                last;
  logic                done_next;
  logic [64:0]         prod;
  logic [EXP_W-1:0]    r_next;

  // quotient of 2^21 or more gives exp = 0
  assign sat  = req.num >= {req.den, ED_Q_W'(0)};
  assign ge   = rem >= {1'b0, dsh};
  assign last = cnt == 5'(ED_Q_W - 1);

  assign prod   = 65'(r) * 65'(exp_factor(cnt)) + 65'(33'h080000000);
  assign r_next = q[cnt] ? prod[64:32] : r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ED_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_comb begin
    state_next = state;
    done_next  = 1'b0;
    case (state)
      ED_IDLE: begin
        if (req.start) begin
          if (sat) begin
            done_next = 1'b1;
          end else begin
            state_next = ED_DIV;
          end
        end
      end
      ED_DIV: begin
        if (last) begin
          state_next = ED_EXP;
        end
      end
      ED_EXP: begin
        if (last) begin
          state_next = ED_IDLE;
          done_next  = 1'b1;
        end
      end
      default: state_next = ED_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      ED_IDLE: begin
        if (req.start) begin
          rem <= req.num;
          dsh <= {req.den, (ED_Q_W - 1)'(0)};
          cnt <= '0;
          r   <= sat ? '0 : {1'b1, 32'h0};
        end
      end
      ED_DIV: begin
        if (ge) begin
          rem <= rem - {1'b0, dsh};
        end
        q   <= {q[ED_Q_W-2:0], ge};
        dsh <= dsh >> 1;
        cnt <= last ? '0 : cnt + 5'd1;
      end
      ED_EXP: begin
        r   <= r_next;
        cnt <= cnt + 5'd1;
      end
      default: ;
    endcase
  end

  assign res = r;

endmodule

`default_nettype wire
